### design/cnti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnti_pkg
// Shared types, code points and decode helpers for the numeral converter.
// ----------------------------------------------------------------------------
package cnti_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 63;
	localparam int unsigned CODE_WIDTH      = 16;

	// character codes (BMP code points)
	localparam logic [CODE_WIDTH-1:0] CP_ZERO      = 16'h96F6;
	localparam logic [CODE_WIDTH-1:0] CP_ZERO_ALT  = 16'h3007;
	localparam logic [CODE_WIDTH-1:0] CP_ONE       = 16'h4E00;
	localparam logic [CODE_WIDTH-1:0] CP_TWO       = 16'h4E8C;
	localparam logic [CODE_WIDTH-1:0] CP_TWO_ALT   = 16'h4E24;
	localparam logic [CODE_WIDTH-1:0] CP_THREE     = 16'h4E09;
	localparam logic [CODE_WIDTH-1:0] CP_FOUR      = 16'h56DB;
	localparam logic [CODE_WIDTH-1:0] CP_FIVE      = 16'h4E94;
	localparam logic [CODE_WIDTH-1:0] CP_SIX       = 16'h516D;
	localparam logic [CODE_WIDTH-1:0] CP_SEVEN     = 16'h4E03;
	localparam logic [CODE_WIDTH-1:0] CP_EIGHT     = 16'h516B;
	localparam logic [CODE_WIDTH-1:0] CP_NINE      = 16'h4E5D;
	localparam logic [CODE_WIDTH-1:0] CP_TEN       = 16'h5341;
	localparam logic [CODE_WIDTH-1:0] CP_HUNDRED   = 16'h767E;
	localparam logic [CODE_WIDTH-1:0] CP_THOUSAND  = 16'h5343;
	localparam logic [CODE_WIDTH-1:0] CP_WAN       = 16'h4E07;
	localparam logic [CODE_WIDTH-1:0] CP_YI        = 16'h4EBF;

	typedef struct packed {
		logic seen_yi;
		logic seen_wan;
		logic ovf;
		logic inv;
	} cnti_flags_t;

	typedef struct packed {
		logic       is_digit;
		logic [3:0] val;
	} cnti_digit_t;

	function automatic cnti_digit_t digit_decode(input logic [CODE_WIDTH-1:0] c);
		cnti_digit_t d;
		d.is_digit = 1'b1;
		case (c)
			CP_ZERO, CP_ZERO_ALT: d.val = 4'd0;
			CP_ONE:               d.val = 4'd1;
			CP_TWO, CP_TWO_ALT:   d.val = 4'd2;
			CP_THREE:             d.val = 4'd3;
			CP_FOUR:              d.val = 4'd4;
			CP_FIVE:              d.val = 4'd5;
			CP_SIX:               d.val = 4'd6;
			CP_SEVEN:             d.val = 4'd7;
			CP_EIGHT:             d.val = 4'd8;
			CP_NINE:              d.val = 4'd9;
			default: begin
				d.is_digit = 1'b0;
				d.val      = 4'd0;
			end
		endcase
		return d;
	endfunction

endpackage

### design/cnti_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnti_char_if
// Character request channel: one code point and a last mark.
// ----------------------------------------------------------------------------
interface cnti_char_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_code;
	logic        last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

### design/cnti_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnti_result_if
// Result request channel: converted value with overflow and invalid flags.
// ----------------------------------------------------------------------------
interface cnti_result_if #(
	parameter int unsigned VALUE_WIDTH = 63
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;
	logic                   overflow;
	logic                   invalid;

	modport source (output valid, output value, output overflow, output invalid,
		input ready);
	modport sink   (input valid, input value, input overflow, input invalid,
		output ready);
endinterface

### design/chinese_numeral_to_integer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chinese_numeral_to_integer
// Converts a run of numeral characters, one per request, to a saturated value.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle; a last one waits on a full result stage.
// The result of a run passes from its last character through the input
// register, the state update and the final sum into the output register.
// Non-last characters keep flowing while a result waits at the output.
// Reset (arst_n low) clears the run state and empties all stages; the run
// state also returns to zero after every last character.
// ----------------------------------------------------------------------------
module chinese_numeral_to_integer #(
	parameter int unsigned VALUE_WIDTH = cnti_pkg::VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cnti_char_if.sink            char_in,
	cnti_result_if.source        result_out
);
	import cnti_pkg::*;

	// input stage
	logic                   valid_s1;
	logic [CODE_WIDTH-1:0]  char_s1;
	logic                   last_s1;

	// run state
	logic [VALUE_WIDTH-1:0] pend_q, sec_q, tot_q;
	cnti_flags_t            flags_q;

	// finished run awaiting the final sum
	logic                   valid_s2;
	logic [VALUE_WIDTH-1:0] pend_s2, sec_s2, tot_s2;
	cnti_flags_t            flags_s2;

	// output register
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   ovf_q, inv_q;

	logic [VALUE_WIDTH-1:0] pend_nxt, sec_nxt, tot_nxt;
	cnti_flags_t            flags_nxt;

	logic out_free, s2_go, s2_free, s1_go, s1_free;
	logic [VALUE_WIDTH:0] fin_a, fin_b;
	logic [VALUE_WIDTH-1:0] fin_a_sat, fin_val;
	logic fin_ovf;

	cnti_step #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_step (
		.char_code (char_s1),
		.pend      (pend_q),
		.sec       (sec_q),
		.tot       (tot_q),
		.flags     (flags_q),
		.pend_nxt  (pend_nxt),
		.sec_nxt   (sec_nxt),
		.tot_nxt   (tot_nxt),
		.flags_nxt (flags_nxt)
	);

	always_comb begin
		out_free = !out_valid_q || result_out.ready;
		s2_go    = valid_s2 && out_free;
		s2_free  = !valid_s2 || out_free;
		// only a last character needs room downstream
		s1_go    = valid_s1 && (!last_s1 || s2_free);
		s1_free  = !valid_s1 || s1_go;
	end

	assign char_in.ready = s1_free;

	// final value: total + (section + pending), each add saturating
	always_comb begin
		fin_a     = {1'b0, sec_s2} + {1'b0, pend_s2};
		fin_a_sat = fin_a[VALUE_WIDTH] ? {VALUE_WIDTH{1'b1}} : fin_a[VALUE_WIDTH-1:0];
		fin_b     = {1'b0, tot_s2} + {1'b0, fin_a_sat};
		fin_val   = fin_b[VALUE_WIDTH] ? {VALUE_WIDTH{1'b1}} : fin_b[VALUE_WIDTH-1:0];
		fin_ovf   = flags_s2.ovf | fin_a[VALUE_WIDTH] | fin_b[VALUE_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= '0;
			sec_q       <= '0;
			tot_q       <= '0;
			flags_q     <= '0;
		end else begin
			if (s1_free)
				valid_s1 <= char_in.valid;

			if (s1_go && last_s1)
				valid_s2 <= 1'b1;
			else if (s2_go)
				valid_s2 <= 1'b0;

			if (s2_go)
				out_valid_q <= 1'b1;
			else if (result_out.ready)
				out_valid_q <= 1'b0;

			if (s1_go) begin
				if (last_s1) begin
					pend_q  <= '0;
					sec_q   <= '0;
					tot_q   <= '0;
					flags_q <= '0;
				end else begin
					pend_q  <= pend_nxt;
					sec_q   <= sec_nxt;
					tot_q   <= tot_nxt;
					flags_q <= flags_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			char_s1 <= char_in.char_code;
			last_s1 <= char_in.last;
		end
		if (s1_go && last_s1) begin
			pend_s2  <= pend_nxt;
			sec_s2   <= sec_nxt;
			tot_s2   <= tot_nxt;
			flags_s2 <= flags_nxt;
		end
		if (s2_go) begin
			value_q <= flags_s2.inv ? '0 : fin_val;
			ovf_q   <= fin_ovf;
			inv_q   <= flags_s2.inv;
		end
	end

	assign result_out.valid    = out_valid_q;
	assign result_out.value    = value_q;
	assign result_out.overflow = ovf_q;
	assign result_out.invalid  = inv_q;

	// an invalid run always reports zero
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && inv_q |-> value_q == '0)
		else $error("invalid result carries a nonzero value");

	// the run state is back at zero after a last character
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> pend_q == '0 && sec_q == '0 && tot_q == '0
			&& flags_q == '0)
		else $error("run state not cleared after last character");

	// a finished run waiting for the output register is not overwritten
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(tot_s2) && $stable(flags_s2))
		else $error("pending run lost while output stalled");

	// a last character never advances while the result stage is blocked
	a_last_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !s2_free |-> !char_in.ready)
		else $error("last character accepted over a full result stage");

endmodule

### design/cnti_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnti_step
// Next-state logic for one character: saturating constant scaling and sums.
// ----------------------------------------------------------------------------
module cnti_step #(
	parameter int unsigned VALUE_WIDTH = cnti_pkg::VALUE_WIDTH_DEF
) (
	input  logic [cnti_pkg::CODE_WIDTH-1:0] char_code,
	input  logic [VALUE_WIDTH-1:0]          pend,
	input  logic [VALUE_WIDTH-1:0]          sec,
	input  logic [VALUE_WIDTH-1:0]          tot,
	input  cnti_pkg::cnti_flags_t           flags,
	output logic [VALUE_WIDTH-1:0]          pend_nxt,
	output logic [VALUE_WIDTH-1:0]          sec_nxt,
	output logic [VALUE_WIDTH-1:0]          tot_nxt,
	output cnti_pkg::cnti_flags_t           flags_nxt
);
	import cnti_pkg::*;

	localparam logic [VALUE_WIDTH-1:0] VMAX   = {VALUE_WIDTH{1'b1}};
	localparam logic [VALUE_WIDTH-1:0] W10    = VALUE_WIDTH'(10);
	localparam logic [VALUE_WIDTH-1:0] W100   = VALUE_WIDTH'(100);
	localparam logic [VALUE_WIDTH-1:0] W1000  = VALUE_WIDTH'(1000);
	localparam logic [VALUE_WIDTH-1:0] W1E4   = VALUE_WIDTH'(10000);
	localparam logic [VALUE_WIDTH-1:0] W1E8   = VALUE_WIDTH'(100000000);
	localparam logic [VALUE_WIDTH-1:0] LIM10  = VMAX / W10;
	localparam logic [VALUE_WIDTH-1:0] LIM100 = VMAX / W100;
	localparam logic [VALUE_WIDTH-1:0] LIM1K  = VMAX / W1000;
	localparam logic [VALUE_WIDTH-1:0] LIM1E4 = VMAX / W1E4;
	localparam logic [VALUE_WIDTH-1:0] LIM1E8 = VMAX / W1E8;

	// msb of the result is the saturation mark
	function automatic logic [VALUE_WIDTH:0] sat_add(
		input logic [VALUE_WIDTH-1:0] a,
		input logic [VALUE_WIDTH-1:0] b
	);
		logic [VALUE_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[VALUE_WIDTH])
			return {1'b1, VMAX};
		return s;
	endfunction

	function automatic logic [VALUE_WIDTH:0] sat_mul(
		input logic [VALUE_WIDTH-1:0] a,
		input logic [VALUE_WIDTH-1:0] k,
		input logic [VALUE_WIDTH-1:0] lim
	);
		logic [VALUE_WIDTH-1:0] p;
		p = a * k;
		if (a > lim)
			return {1'b1, VMAX};
		return {1'b0, p};
	endfunction

	cnti_digit_t            dig;
	logic [VALUE_WIDTH-1:0] unit_m;
	logic [VALUE_WIDTH:0]   unit_mul10, unit_mul100, unit_mul1k;
	logic [VALUE_WIDTH:0]   unit_mul, unit_sum;
	logic [VALUE_WIDTH:0]   close_s, close_mul1e4, close_mul1e8;
	logic [VALUE_WIDTH:0]   close_mul, close_sum;
	logic [VALUE_WIDTH:0]   dig_mul, dig_sum;

	always_comb begin
		dig = digit_decode(char_code);

		// one constant multiply per weight, the code picks the product
		unit_m      = (pend == '0) ? VALUE_WIDTH'(1) : pend;
		unit_mul10  = sat_mul(unit_m, W10, LIM10);
		unit_mul100 = sat_mul(unit_m, W100, LIM100);
		unit_mul1k  = sat_mul(unit_m, W1000, LIM1K);
		case (char_code)
			CP_HUNDRED: begin
				unit_mul = unit_mul100;
			end
			CP_THOUSAND: begin
				unit_mul = unit_mul1k;
			end
			default: begin
				unit_mul = unit_mul10;
			end
		endcase
		unit_sum = sat_add(sec, unit_mul[VALUE_WIDTH-1:0]);

		close_s      = sat_add(sec, pend);
		close_mul1e4 = sat_mul(close_s[VALUE_WIDTH-1:0], W1E4, LIM1E4);
		close_mul1e8 = sat_mul(close_s[VALUE_WIDTH-1:0], W1E8, LIM1E8);
		close_mul    = (char_code == CP_YI) ? close_mul1e8 : close_mul1e4;
		close_sum    = sat_add(tot, close_mul[VALUE_WIDTH-1:0]);

		dig_mul = sat_mul(pend, W10, LIM10);
		dig_sum = sat_add(dig_mul[VALUE_WIDTH-1:0], VALUE_WIDTH'(dig.val));

		pend_nxt  = pend;
		sec_nxt   = sec;
		tot_nxt   = tot;
		flags_nxt = flags;

		case (char_code)
			CP_ZERO: begin
				pend_nxt = '0;
			end
			CP_TEN, CP_HUNDRED, CP_THOUSAND: begin
				sec_nxt       = unit_sum[VALUE_WIDTH-1:0];
				pend_nxt      = '0;
				flags_nxt.ovf = flags.ovf | unit_mul[VALUE_WIDTH] | unit_sum[VALUE_WIDTH];
			end
			CP_YI, CP_WAN: begin
				// yi is refused once either mark was seen, wan only after a wan
				if (flags.seen_wan || (char_code == CP_YI && flags.seen_yi)) begin
					flags_nxt.inv = 1'b1;
				end else begin
					if (char_code == CP_YI)
						flags_nxt.seen_yi = 1'b1;
					else
						flags_nxt.seen_wan = 1'b1;
					tot_nxt       = close_sum[VALUE_WIDTH-1:0];
					sec_nxt       = '0;
					pend_nxt      = '0;
					flags_nxt.ovf = flags.ovf | close_s[VALUE_WIDTH]
						| close_mul[VALUE_WIDTH] | close_sum[VALUE_WIDTH];
				end
			end
			default: begin
				if (!dig.is_digit) begin
					flags_nxt.inv = 1'b1;
				end else begin
					pend_nxt      = dig_sum[VALUE_WIDTH-1:0];
					flags_nxt.ovf = flags.ovf | dig_mul[VALUE_WIDTH] | dig_sum[VALUE_WIDTH];
				end
			end
		endcase
	end

endmodule
